// ----- rtl/bms_pkg.sv -----
package bms_pkg;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  localparam int unsigned BYTE_VALUES = 256;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_BC_RD,
    ST_BC_WR,
    ST_GS_INIT,
    ST_OUT,
    ST_OUT_WT,
    ST_IN_CHK,
    ST_IN_CMP,
    ST_IN_UPD,
    ST_STEP,
    ST_FIN_RD0,
    ST_FIN_WT0,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_SC_WIN,
    ST_SC_RD,
    ST_SC_CMP,
    ST_SC_MIS,
    ST_SC_MBC,
    ST_SC_MADV,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/bms_ram.sv -----
module bms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/boyer_moore_search.sv -----
// Boyer-Moore search over a stored pattern and text. A byte transfer is accepted
// whenever start_i is high while busy_o is low. The last pattern byte starts table
// preparation: a sweep over all byte values that resets the bad-character memory, a
// read and a write per pattern byte to fill it, then the good-suffix pass over each
// pattern position and its border chain, then the final fill of the good-suffix table.
// The last text byte starts the scan if a ready pattern fits in the text, reading each
// compared byte through the one read port of the pattern and text memories. Each
// match is reported one match later (or at scan end) so that is_final_o is known;
// results come as one-cycle valid_o strobes and the receiver cannot stall them.
// busy_o stays high until the final result is out.
module boyer_moore_search #(
  parameter int unsigned PAT_DEPTH  = 16,
  parameter int unsigned TEXT_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       valid_o,
  output logic [5:0] position_o,
  output logic       found_o,
  output logic       is_final_o,
  output logic       truncated_o
);

  localparam int unsigned PA = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int unsigned TA = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int unsigned MW = $clog2(PAT_DEPTH + 1);
  localparam int unsigned NW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned GD = PAT_DEPTH + 2;
  localparam int unsigned GA = $clog2(GD);
  localparam int unsigned BW = MW + 1;
  localparam int unsigned SW = $clog2(TEXT_DEPTH + 2);
  localparam int unsigned DW = ((SW > MW) ? SW : MW) + 2;

  bms_pkg::state_e state_q, state_d;

  logic [MW-1:0] pat_len_q, pat_len_d;
  logic          pat_cut_q, pat_cut_d;
  logic          pat_ready_q, pat_ready_d;
  logic          pat_open_q, pat_open_d;
  logic [NW-1:0] txt_len_q, txt_len_d;
  logic          txt_cut_q, txt_cut_d;
  logic          txt_open_q, txt_open_d;
  logic [7:0]    idx_q, idx_d;
  logic [GA-1:0] i_q, i_d, j_q, j_d;
  logic [7:0]    a_q, a_d;
  logic [SW-1:0] s_q, s_d;
  logic [MW-1:0] k_q, k_d;
  logic          pend_vld_q, pend_vld_d;
  logic [SW-1:0] pend_pos_q, pend_pos_d;
  logic          valid_q, valid_d;
  logic [5:0]    pos_q, pos_d;
  logic          found_q, found_d;
  logic          final_q, final_d;
  logic          trunc_q, trunc_d;

  // memory ports
  logic          pat_we;
  logic [PA-1:0] pat_waddr, pat_raddr;
  logic [7:0]    pat_rdata;
  logic          txt_we;
  logic [TA-1:0] txt_waddr, txt_raddr;
  logic [7:0]    txt_rdata;
  logic          bc_we;
  logic [7:0]    bc_waddr, bc_raddr;
  logic [BW-1:0] bc_wdata, bc_rdata;
  logic          gs_we;
  logic [GA-1:0] gs_waddr, gs_raddr, gs_wdata, gs_rdata;
  logic          bp_we;
  logic [GA-1:0] bp_waddr, bp_raddr, bp_wdata, bp_rdata;

  // helper values
  logic          accept;
  logic [MW-1:0] cur_pl;
  logic [NW-1:0] cur_tl, new_tl;
  logic          new_tcut;
  logic          win_over;
  logic          pat_hit;
  logic          tail_in;
  logic signed [BW-1:0] bc_sig;
  logic signed [DW-1:0] bc_shift, gs_shift, mis_adv, mat_adv;

  assign accept = start_i && (state_q == bms_pkg::ST_IDLE);
  assign cur_pl = pat_open_q ? pat_len_q : '0;
  assign cur_tl = txt_open_q ? txt_len_q : '0;
  assign new_tl = (cur_tl < NW'(TEXT_DEPTH)) ? cur_tl + NW'(1) : cur_tl;
  assign new_tcut = (cur_tl < NW'(TEXT_DEPTH)) ? (txt_open_q && txt_cut_q) : 1'b1;
  assign win_over = (DW'(s_q) + DW'(pat_len_q)) > DW'(txt_len_q);
  assign tail_in = (DW'(s_q) + DW'(pat_len_q)) < DW'(txt_len_q);
  assign pat_hit = (pat_rdata == txt_rdata);
  assign bc_sig = $signed(bc_rdata);
  assign bc_shift = $signed(DW'(k_q)) - DW'(bc_sig);
  assign gs_shift = $signed(DW'(gs_rdata));
  assign mis_adv = (bc_shift > gs_shift) ? bc_shift : gs_shift;
  assign mat_adv = $signed(DW'(pat_len_q)) - DW'(bc_sig);

  bms_ram #(.WIDTH(8), .DEPTH(PAT_DEPTH)) u_pat_ram (
    .clk_i, .we_i(pat_we), .waddr_i(pat_waddr), .wdata_i(data_byte_i),
    .raddr_i(pat_raddr), .rdata_o(pat_rdata)
  );

  bms_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_txt_ram (
    .clk_i, .we_i(txt_we), .waddr_i(txt_waddr), .wdata_i(data_byte_i),
    .raddr_i(txt_raddr), .rdata_o(txt_rdata)
  );

  bms_ram #(.WIDTH(BW), .DEPTH(bms_pkg::BYTE_VALUES)) u_bc_ram (
    .clk_i, .we_i(bc_we), .waddr_i(bc_waddr), .wdata_i(bc_wdata),
    .raddr_i(bc_raddr), .rdata_o(bc_rdata)
  );

  bms_ram #(.WIDTH(GA), .DEPTH(GD)) u_gs_ram (
    .clk_i, .we_i(gs_we), .waddr_i(gs_waddr), .wdata_i(gs_wdata),
    .raddr_i(gs_raddr), .rdata_o(gs_rdata)
  );

  bms_ram #(.WIDTH(GA), .DEPTH(GD)) u_bp_ram (
    .clk_i, .we_i(bp_we), .waddr_i(bp_waddr), .wdata_i(bp_wdata),
    .raddr_i(bp_raddr), .rdata_o(bp_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bms_pkg::ST_IDLE: begin
        if (accept && last_i) begin
          if (op_i == bms_pkg::OP_PATTERN) begin
            state_d = bms_pkg::ST_CLR;
          end else if (pat_ready_q && (DW'(pat_len_q) <= DW'(new_tl))) begin
            state_d = bms_pkg::ST_SC_WIN;
          end else begin
            state_d = bms_pkg::ST_DONE;
          end
        end
      end
      bms_pkg::ST_CLR:     if (idx_q == 8'd255) state_d = bms_pkg::ST_BC_RD;
      bms_pkg::ST_BC_RD:   state_d = bms_pkg::ST_BC_WR;
      bms_pkg::ST_BC_WR: begin
        if ((idx_q + 8'd1) == 8'(pat_len_q)) state_d = bms_pkg::ST_GS_INIT;
        else state_d = bms_pkg::ST_BC_RD;
      end
      bms_pkg::ST_GS_INIT: state_d = bms_pkg::ST_OUT;
      bms_pkg::ST_OUT: begin
        if (i_q == '0) state_d = bms_pkg::ST_FIN_RD0;
        else state_d = bms_pkg::ST_OUT_WT;
      end
      bms_pkg::ST_OUT_WT:  state_d = bms_pkg::ST_IN_CHK;
      bms_pkg::ST_IN_CHK: begin
        if (GA'(j_q) > GA'(pat_len_q)) state_d = bms_pkg::ST_STEP;
        else state_d = bms_pkg::ST_IN_CMP;
      end
      bms_pkg::ST_IN_CMP: begin
        if (pat_rdata == a_q) state_d = bms_pkg::ST_STEP;
        else state_d = bms_pkg::ST_IN_UPD;
      end
      bms_pkg::ST_IN_UPD:  state_d = bms_pkg::ST_IN_CHK;
      bms_pkg::ST_STEP:    state_d = bms_pkg::ST_OUT;
      bms_pkg::ST_FIN_RD0: state_d = bms_pkg::ST_FIN_WT0;
      bms_pkg::ST_FIN_WT0: state_d = bms_pkg::ST_FIN_RD;
      bms_pkg::ST_FIN_RD:  state_d = bms_pkg::ST_FIN_WR;
      bms_pkg::ST_FIN_WR: begin
        if (i_q == GA'(pat_len_q)) state_d = bms_pkg::ST_IDLE;
        else state_d = bms_pkg::ST_FIN_RD;
      end
      bms_pkg::ST_SC_WIN: begin
        if (win_over) state_d = bms_pkg::ST_DONE;
        else state_d = bms_pkg::ST_SC_RD;
      end
      bms_pkg::ST_SC_RD:   state_d = bms_pkg::ST_SC_CMP;
      bms_pkg::ST_SC_CMP: begin
        if (!pat_hit) state_d = bms_pkg::ST_SC_MIS;
        else if (k_q != '0) state_d = bms_pkg::ST_SC_RD;
        else if (tail_in) state_d = bms_pkg::ST_SC_MBC;
        else state_d = bms_pkg::ST_SC_WIN;
      end
      bms_pkg::ST_SC_MIS:  state_d = bms_pkg::ST_SC_WIN;
      bms_pkg::ST_SC_MBC:  state_d = bms_pkg::ST_SC_MADV;
      bms_pkg::ST_SC_MADV: state_d = bms_pkg::ST_SC_WIN;
      bms_pkg::ST_DONE:    state_d = bms_pkg::ST_IDLE;
      default:             state_d = bms_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pat_len_d   = pat_len_q;
    pat_cut_d   = pat_cut_q;
    pat_ready_d = pat_ready_q;
    pat_open_d  = pat_open_q;
    txt_len_d   = txt_len_q;
    txt_cut_d   = txt_cut_q;
    txt_open_d  = txt_open_q;
    idx_d       = idx_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    s_d         = s_q;
    k_d         = k_q;
    pend_vld_d  = pend_vld_q;
    pend_pos_d  = pend_pos_q;
    valid_d     = 1'b0;
    pos_d       = pos_q;
    found_d     = found_q;
    final_d     = final_q;
    trunc_d     = trunc_q;
    pat_we = 1'b0; pat_waddr = PA'(cur_pl); pat_raddr = '0;
    txt_we = 1'b0; txt_waddr = TA'(cur_tl); txt_raddr = '0;
    bc_we = 1'b0; bc_waddr = idx_q; bc_wdata = '1; bc_raddr = '0;
    gs_we = 1'b0; gs_waddr = '0; gs_wdata = '0; gs_raddr = '0;
    bp_we = 1'b0; bp_waddr = '0; bp_wdata = '0; bp_raddr = '0;
    case (state_q)
      bms_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i == bms_pkg::OP_PATTERN) begin
            pat_open_d = !last_i;
            if (!pat_open_q) begin
              pat_ready_d = 1'b0;
              pat_cut_d   = 1'b0;
            end
            if (cur_pl < MW'(PAT_DEPTH)) begin
              pat_we    = 1'b1;
              pat_len_d = cur_pl + MW'(1);
            end else begin
              pat_len_d = cur_pl;
              pat_cut_d = 1'b1;
            end
            idx_d = '0;
          end else begin
            txt_open_d = !last_i;
            txt_we     = (cur_tl < NW'(TEXT_DEPTH));
            txt_len_d  = new_tl;
            txt_cut_d  = new_tcut;
            s_d        = '0;
            pend_vld_d = 1'b0;
            trunc_d    = pat_cut_q || new_tcut;
          end
        end
      end
      bms_pkg::ST_CLR: begin
        // sweep the bad-character memory back to -1, clear good-suffix entries in use
        bc_we    = 1'b1;
        gs_we    = (idx_q <= 8'(pat_len_q));
        gs_waddr = GA'(idx_q);
        idx_d    = idx_q + 8'd1;
      end
      bms_pkg::ST_BC_RD: pat_raddr = PA'(idx_q);
      bms_pkg::ST_BC_WR: begin
        bc_we    = 1'b1;
        bc_waddr = pat_rdata;
        bc_wdata = BW'(idx_q);
        idx_d    = idx_q + 8'd1;
      end
      bms_pkg::ST_GS_INIT: begin
        bp_we    = 1'b1;
        bp_waddr = GA'(pat_len_q);
        bp_wdata = GA'(pat_len_q) + GA'(1);
        i_d      = GA'(pat_len_q);
        j_d      = GA'(pat_len_q) + GA'(1);
      end
      bms_pkg::ST_OUT:    pat_raddr = PA'(i_q - GA'(1));
      bms_pkg::ST_OUT_WT: a_d = pat_rdata;
      bms_pkg::ST_IN_CHK: pat_raddr = PA'(j_q - GA'(1));
      bms_pkg::ST_IN_CMP: begin
        gs_raddr = j_q;
        bp_raddr = j_q;
      end
      bms_pkg::ST_IN_UPD: begin
        gs_we    = (gs_rdata == '0);
        gs_waddr = j_q;
        gs_wdata = j_q - i_q;
        j_d      = bp_rdata;
      end
      bms_pkg::ST_STEP: begin
        bp_we    = 1'b1;
        bp_waddr = i_q - GA'(1);
        bp_wdata = j_q - GA'(1);
        i_d      = i_q - GA'(1);
        j_d      = j_q - GA'(1);
      end
      bms_pkg::ST_FIN_RD0: bp_raddr = '0;
      bms_pkg::ST_FIN_WT0: begin
        j_d = bp_rdata;
        i_d = '0;
      end
      bms_pkg::ST_FIN_RD: begin
        gs_raddr = i_q;
        bp_raddr = j_q;
      end
      bms_pkg::ST_FIN_WR: begin
        gs_we    = (gs_rdata == '0);
        gs_waddr = i_q;
        gs_wdata = j_q;
        if ((i_q == j_q) && (j_q <= GA'(pat_len_q))) j_d = bp_rdata;
        i_d = i_q + GA'(1);
        if (i_q == GA'(pat_len_q)) pat_ready_d = 1'b1;
      end
      bms_pkg::ST_SC_WIN: k_d = pat_len_q - MW'(1);
      bms_pkg::ST_SC_RD: begin
        pat_raddr = PA'(k_q);
        txt_raddr = TA'(s_q + SW'(k_q));
      end
      bms_pkg::ST_SC_CMP: begin
        if (!pat_hit) begin
          bc_raddr = txt_rdata;
          gs_raddr = GA'(k_q) + GA'(1);
        end else if (k_q != '0) begin
          k_d = k_q - MW'(1);
        end else begin
          // full match: release the held one, hold this one until its successor is known
          valid_d    = pend_vld_q;
          pos_d      = 6'(pend_pos_q);
          found_d    = 1'b1;
          final_d    = 1'b0;
          pend_vld_d = 1'b1;
          pend_pos_d = s_q;
          txt_raddr  = TA'(s_q + SW'(pat_len_q));
          if (!tail_in) s_d = s_q + SW'(1);
        end
      end
      bms_pkg::ST_SC_MIS: begin
        if (mis_adv < DW'(1)) s_d = s_q + SW'(1);
        else s_d = s_q + SW'(mis_adv);
      end
      bms_pkg::ST_SC_MBC: bc_raddr = txt_rdata;
      bms_pkg::ST_SC_MADV: begin
        if (mat_adv < DW'(1)) s_d = s_q + SW'(1);
        else s_d = s_q + SW'(mat_adv);
      end
      bms_pkg::ST_DONE: begin
        valid_d = 1'b1;
        pos_d   = pend_vld_q ? 6'(pend_pos_q) : 6'd0;
        found_d = pend_vld_q;
        final_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bms_pkg::ST_IDLE;
      pat_len_q   <= '0;
      pat_cut_q   <= 1'b0;
      pat_ready_q <= 1'b0;
      pat_open_q  <= 1'b0;
      txt_len_q   <= '0;
      txt_cut_q   <= 1'b0;
      txt_open_q  <= 1'b0;
      pend_vld_q  <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pat_len_q   <= pat_len_d;
      pat_cut_q   <= pat_cut_d;
      pat_ready_q <= pat_ready_d;
      pat_open_q  <= pat_open_d;
      txt_len_q   <= txt_len_d;
      txt_cut_q   <= txt_cut_d;
      txt_open_q  <= txt_open_d;
      pend_vld_q  <= pend_vld_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    i_q        <= i_d;
    j_q        <= j_d;
    a_q        <= a_d;
    s_q        <= s_d;
    k_q        <= k_d;
    pend_pos_q <= pend_pos_d;
    pos_q      <= pos_d;
    found_q    <= found_d;
    final_q    <= final_d;
    trunc_q    <= trunc_d;
  end

  assign busy_o      = (state_q != bms_pkg::ST_IDLE);
  assign valid_o     = valid_q;
  assign position_o  = pos_q;
  assign found_o     = found_q;
  assign is_final_o  = final_q;
  assign truncated_o = trunc_q;

  a_final_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_final_o |=> !valid_o)
    else $error("result after the final one");

  a_notfound_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !found_o |-> is_final_o)
    else $error("not-found result that is not final");

  a_ready_from_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pat_ready_q) |-> $past(state_q) == bms_pkg::ST_FIN_WR)
    else $error("pattern ready outside table build");

  a_scan_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bms_pkg::ST_SC_CMP |-> (DW'(s_q) + DW'(k_q)) < DW'(txt_len_q))
    else $error("scan compare beyond stored text");

endmodule
